### hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// Block pool allocator package
// Sizes, request and status codes, sequencer states and the link write port
// type shared by the allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fbpa_pkg;

   localparam int MAX_BUFFERS           = 8;
   localparam int BLOCKS_PER_BUFFER_MAX = 256;

   localparam int BUF_W    = $clog2(MAX_BUFFERS);
   localparam int IDX_W    = $clog2(BLOCKS_PER_BUFFER_MAX);
   localparam int HANDLE_W = BUF_W + IDX_W;
   localparam int CNT_W    = IDX_W + 1;
   localparam int OPEN_W   = $clog2(MAX_BUFFERS + 1);
   localparam int LINK_DEPTH = MAX_BUFFERS * BLOCKS_PER_BUFFER_MAX;

   localparam logic [CNT_W-1:0] BLOCKS_RESET = CNT_W'(BLOCKS_PER_BUFFER_MAX);

   localparam logic [1:0] REQ_ALLOC    = 2'd0;
   localparam logic [1:0] REQ_FREE     = 2'd1;
   localparam logic [1:0] REQ_FREE_ALL = 2'd2;
   localparam logic [1:0] REQ_UNUSED   = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_EXHAUSTED  = 2'd1;
   localparam logic [1:0] STATUS_BAD_HANDLE = 2'd2;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_SCAN,
      ST_READ,
      ST_POP,
      ST_FREE
   } state_type;

   typedef struct packed {
      logic                en;
      logic [HANDLE_W-1:0] addr;
      logic [CNT_W-1:0]    data;
   } link_wr_type;

endpackage

`default_nettype wire

### hw/rtl/fbpa_link_ram.sv
// ----------------------------------------------------------------------------
// Link store
// Single write port, single read port memory holding the next-block links of
// every buffer's free list. Read data is registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbpa_link_ram (
   input  wire                             clock,
   input  fbpa_pkg::link_wr_type           wr,
   input  wire [fbpa_pkg::HANDLE_W-1:0]    rd_addr,
   output logic [fbpa_pkg::CNT_W-1:0]      rd_data
);

   logic [fbpa_pkg::CNT_W-1:0] mem [fbpa_pkg::LINK_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### hw/rtl/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Holds the per-buffer heads and free counts and steps one buffer at a time
// through scan, pop, push and the link initialization walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fbpa_ctrl (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   input  wire [1:0]                         req_type,
   input  wire [fbpa_pkg::HANDLE_W-1:0]      block_handle,
   input  wire [fbpa_pkg::CNT_W-1:0]         blocks_eff,
   output logic                              busy,
   output logic                              rsp_valid,
   output logic [fbpa_pkg::HANDLE_W-1:0]     rsp_handle,
   output logic [1:0]                        rsp_status,
   output fbpa_pkg::link_wr_type             link_wr,
   output logic [fbpa_pkg::HANDLE_W-1:0]     link_raddr,
   input  wire [fbpa_pkg::CNT_W-1:0]         link_rdata
);

   fbpa_pkg::state_type state_ff, state_in;
   logic [fbpa_pkg::BUF_W-1:0]    cur_ff, cur_in;
   logic [fbpa_pkg::IDX_W-1:0]    walk_ff, walk_in;
   logic [fbpa_pkg::OPEN_W-1:0]   open_ff, open_in;
   logic                          pend_alloc_ff, pend_alloc_in;
   logic                          rsp_done_ff, rsp_done_in;
   logic [fbpa_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic [fbpa_pkg::CNT_W-1:0]    head_ff  [fbpa_pkg::MAX_BUFFERS];
   logic [fbpa_pkg::CNT_W-1:0]    head_in  [fbpa_pkg::MAX_BUFFERS];
   logic [fbpa_pkg::CNT_W-1:0]    count_ff [fbpa_pkg::MAX_BUFFERS];
   logic [fbpa_pkg::CNT_W-1:0]    count_in [fbpa_pkg::MAX_BUFFERS];
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [fbpa_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [1:0]                    rsp_status_ff, rsp_status_in;

   logic [fbpa_pkg::CNT_W-1:0]    walk_next;
   logic [fbpa_pkg::IDX_W-1:0]    head_idx;
   logic                          bad_handle;

   assign busy       = (state_ff != fbpa_pkg::ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_handle = rsp_handle_ff;
   assign rsp_status = rsp_status_ff;

   assign walk_next  = {1'b0, walk_ff} + fbpa_pkg::CNT_W'(1);
   assign head_idx   = head_ff[cur_ff][fbpa_pkg::IDX_W-1:0];
   assign bad_handle = ({1'b0, cur_ff} >= open_ff) || ({1'b0, idx_ff} >= blocks_eff);
   assign link_raddr = {cur_ff, head_idx};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fbpa_pkg::ST_INIT;
         cur_ff        <= '0;
         walk_ff       <= '0;
         open_ff       <= fbpa_pkg::OPEN_W'(1);
         pend_alloc_ff <= 1'b0;
         rsp_done_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int b = 0; b < fbpa_pkg::MAX_BUFFERS; b++) begin
            head_ff[b]  <= '0;
            count_ff[b] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         walk_ff       <= walk_in;
         open_ff       <= open_in;
         pend_alloc_ff <= pend_alloc_in;
         rsp_done_ff   <= rsp_done_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_status_ff <= rsp_status_in;
   end

   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      walk_in       = walk_ff;
      open_in       = open_ff;
      pend_alloc_in = pend_alloc_ff;
      rsp_done_in   = rsp_done_ff;
      idx_in        = idx_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_handle_in = rsp_handle_ff;
      rsp_status_in = rsp_status_ff;
      link_wr       = '{en: 1'b0, addr: '0, data: '0};

      unique case (state_ff)
         fbpa_pkg::ST_INIT: begin
            // Lay down the ascending free list one link per cycle.
            link_wr = '{en: 1'b1, addr: {cur_ff, walk_ff}, data: walk_next};
            walk_in = walk_ff + fbpa_pkg::IDX_W'(1);
            if (walk_next == blocks_eff) begin
               walk_in          = '0;
               head_in[cur_ff]  = '0;
               count_in[cur_ff] = blocks_eff;
               pend_alloc_in    = 1'b0;
               rsp_done_in      = 1'b0;
               if (pend_alloc_ff) begin
                  state_in = fbpa_pkg::ST_READ;
               end else begin
                  state_in = fbpa_pkg::ST_IDLE;
                  if (rsp_done_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_handle_in = '0;
                     rsp_status_in = fbpa_pkg::STATUS_OK;
                  end
               end
            end
         end

         fbpa_pkg::ST_IDLE: begin
            if (start) begin
               unique case (req_type)
                  fbpa_pkg::REQ_ALLOC: begin
                     cur_in   = fbpa_pkg::BUF_W'(open_ff - fbpa_pkg::OPEN_W'(1));
                     state_in = fbpa_pkg::ST_SCAN;
                  end
                  fbpa_pkg::REQ_FREE: begin
                     cur_in   = block_handle[fbpa_pkg::HANDLE_W-1:fbpa_pkg::IDX_W];
                     idx_in   = block_handle[fbpa_pkg::IDX_W-1:0];
                     state_in = fbpa_pkg::ST_FREE;
                  end
                  fbpa_pkg::REQ_FREE_ALL: begin
                     for (int b = 1; b < fbpa_pkg::MAX_BUFFERS; b++) begin
                        head_in[b]  = '0;
                        count_in[b] = '0;
                     end
                     open_in       = fbpa_pkg::OPEN_W'(1);
                     cur_in        = '0;
                     walk_in       = '0;
                     pend_alloc_in = 1'b0;
                     rsp_done_in   = 1'b1;
                     state_in      = fbpa_pkg::ST_INIT;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_handle_in = '0;
                     rsp_status_in = fbpa_pkg::STATUS_OK;
                  end
               endcase
            end
         end

         fbpa_pkg::ST_SCAN: begin
            // Newest buffer first, one free count compared per cycle.
            if (count_ff[cur_ff] != '0) begin
               state_in = fbpa_pkg::ST_READ;
            end else if (cur_ff != '0) begin
               cur_in = cur_ff - fbpa_pkg::BUF_W'(1);
            end else if (open_ff < fbpa_pkg::OPEN_W'(fbpa_pkg::MAX_BUFFERS)) begin
               cur_in        = fbpa_pkg::BUF_W'(open_ff);
               open_in       = open_ff + fbpa_pkg::OPEN_W'(1);
               walk_in       = '0;
               pend_alloc_in = 1'b1;
               rsp_done_in   = 1'b0;
               state_in      = fbpa_pkg::ST_INIT;
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_handle_in = '0;
               rsp_status_in = fbpa_pkg::STATUS_EXHAUSTED;
               state_in      = fbpa_pkg::ST_IDLE;
            end
         end

         fbpa_pkg::ST_READ: begin
            // The head's link is being read; it arrives in the next cycle.
            state_in = fbpa_pkg::ST_POP;
         end

         fbpa_pkg::ST_POP: begin
            head_in[cur_ff]  = link_rdata;
            count_in[cur_ff] = count_ff[cur_ff] - fbpa_pkg::CNT_W'(1);
            rsp_valid_in     = 1'b1;
            rsp_handle_in    = {cur_ff, head_idx};
            rsp_status_in    = fbpa_pkg::STATUS_OK;
            state_in         = fbpa_pkg::ST_IDLE;
         end

         fbpa_pkg::ST_FREE: begin
            rsp_valid_in  = 1'b1;
            rsp_handle_in = '0;
            state_in      = fbpa_pkg::ST_IDLE;
            if (bad_handle) begin
               rsp_status_in = fbpa_pkg::STATUS_BAD_HANDLE;
            end else begin
               rsp_status_in   = fbpa_pkg::STATUS_OK;
               link_wr         = '{en: 1'b1, addr: {cur_ff, idx_ff}, data: head_ff[cur_ff]};
               head_in[cur_ff] = {1'b0, idx_ff};
               if (count_ff[cur_ff] < fbpa_pkg::BLOCKS_RESET) begin
                  count_in[cur_ff] = count_ff[cur_ff] + fbpa_pkg::CNT_W'(1);
               end
            end
         end

         default: begin
            state_in = fbpa_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/fixed_block_pool_allocator.sv
// Allocate: returns a block of the newest open buffer with a free block, skipping empty
// buffers on the way down; lays down a new buffer's free list first when one can still be
// opened, else reports exhaustion. One request at a time; busy, where raised, drops at the
// edge that raises the result strobe. After reset, busy is high while buffer 0's list is
// built.
// ----------------------------------------------------------------------------
// Fixed block pool allocator
// Hands out and takes back fixed-size block handles from a set of buffers,
// each with its own free list kept in a shared link memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_block_pool_allocator (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire [1:0]                         req_type,
   input  wire [fbpa_pkg::HANDLE_W-1:0]      req_block_handle,
   output logic                              rsp_valid,
   output logic [fbpa_pkg::HANDLE_W-1:0]     rsp_granted_handle,
   output logic [1:0]                        rsp_status,
   input  wire                               csr_we,
   input  wire [fbpa_pkg::CNT_W-1:0]         csr_wdata
);

   logic [fbpa_pkg::CNT_W-1:0]    blocks_ff, blocks_in;
   logic [fbpa_pkg::CNT_W-1:0]    blocks_eff;
   fbpa_pkg::link_wr_type         link_wr;
   logic [fbpa_pkg::HANDLE_W-1:0] link_raddr;
   logic [fbpa_pkg::CNT_W-1:0]    link_rdata;

   assign blocks_in = csr_we ? csr_wdata : blocks_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         blocks_ff <= fbpa_pkg::BLOCKS_RESET;
      end else begin
         blocks_ff <= blocks_in;
      end
   end

   // A zero setting still yields one block per buffer; a setting above 256 is clamped to 256.
   always_comb begin
      if (blocks_ff == '0) begin
         blocks_eff = fbpa_pkg::CNT_W'(1);
      end else if (blocks_ff > fbpa_pkg::BLOCKS_RESET) begin
         blocks_eff = fbpa_pkg::BLOCKS_RESET;
      end else begin
         blocks_eff = blocks_ff;
      end
   end

   fbpa_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .req_type     (req_type),
      .block_handle (req_block_handle),
      .blocks_eff   (blocks_eff),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_handle   (rsp_granted_handle),
      .rsp_status   (rsp_status),
      .link_wr      (link_wr),
      .link_raddr   (link_raddr),
      .link_rdata   (link_rdata)
   );

   fbpa_link_ram u_link_ram (
      .clock   (clock),
      .wr      (link_wr),
      .rd_addr (link_raddr),
      .rd_data (link_rdata)
   );

endmodule

`default_nettype wire

### dv/testbench.sv
// ----------------------------------------------------------------------------
// Block pool allocator testbench
// Drives allocate, free, free-all and unused request words through the
// start/busy port and predicts each response word from a shadow copy of the
// free lists, buffer heads, free counts and open buffer count. A directed
// part covers double free, bad handles, pool exhaustion and the unused code.
// Random phases under several block counts then mix allocations and frees
// of granted handles with noise. Every response word is checked field by
// field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import fbpa_pkg::*;

   typedef struct packed {
      logic [1:0]          kind;
      logic [HANDLE_W-1:0] handle;
   } req_word_t;

   typedef struct packed {
      logic [HANDLE_W-1:0] handle;
      logic [1:0]          status;
   } grant_word_t;

   localparam int BPM = BLOCKS_PER_BUFFER_MAX;

   logic                clock;
   logic                reset;
   logic                start = 1'b0;
   logic [1:0]          req_type = REQ_ALLOC;
   logic [HANDLE_W-1:0] req_block_handle = '0;
   logic                csr_we = 1'b0;
   logic [CNT_W-1:0]    csr_wdata = '0;
   logic                busy;
   logic                rsp_valid;
   logic [HANDLE_W-1:0] rsp_granted_handle;
   logic [1:0]          rsp_status;

   fixed_block_pool_allocator dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_type           (req_type),
      .req_block_handle   (req_block_handle),
      .rsp_valid          (rsp_valid),
      .rsp_granted_handle (rsp_granted_handle),
      .rsp_status         (rsp_status),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   // Shadow pool state.
   logic [CNT_W-1:0]    link_mem [LINK_DEPTH];
   logic [CNT_W-1:0]    head_idx [MAX_BUFFERS];
   logic [CNT_W-1:0]    free_cnt [MAX_BUFFERS];
   logic [OPEN_W-1:0]   open_cnt;
   logic [CNT_W-1:0]    blocks_cfg;

   req_word_t           pending_words[$];
   grant_word_t         expected_grants[$];
   logic [HANDLE_W-1:0] live_handles[$];
   req_word_t           next_word;
   grant_word_t         got_grant;
   logic                word_taken = 1'b0;
   logic                burst = 1'b0;
   int                  gap_left = 0;
   int                  failures = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [CNT_W-1:0] usable_blocks();
      if (blocks_cfg == 0)
         return CNT_W'(1);
      if (blocks_cfg > BPM)
         return CNT_W'(BPM);
      return blocks_cfg;
   endfunction

   task automatic build_list(input int b);
      int n;
      n = int'(usable_blocks());
      for (int i = 0; i < n; i++)
         link_mem[b * BPM + i] = CNT_W'(i + 1);
      head_idx[b] = '0;
      free_cnt[b] = CNT_W'(n);
   endtask

   // A head or link past the last block wraps onto an index of the same buffer.
   function automatic logic [HANDLE_W-1:0] pop_block(input int b);
      int idx;
      idx = int'(head_idx[b][IDX_W-1:0]);
      head_idx[b] = link_mem[b * BPM + idx];
      free_cnt[b] = free_cnt[b] - 1'b1;
      return HANDLE_W'(b * BPM + idx);
   endfunction

   task automatic reset_pool();
      blocks_cfg = BLOCKS_RESET;
      for (int i = 0; i < LINK_DEPTH; i++)
         link_mem[i] = '0;
      for (int b = 0; b < MAX_BUFFERS; b++) begin
         head_idx[b] = '0;
         free_cnt[b] = '0;
      end
      open_cnt = OPEN_W'(1);
      build_list(0);
      live_handles.delete();
   endtask

   task automatic serve_request(input logic [1:0] kind, input logic [HANDLE_W-1:0] handle);
      grant_word_t grant;
      int          b;
      int          idx;
      bit          found;
      grant.handle = '0;
      grant.status = STATUS_OK;
      found = 0;
      case (kind)
         REQ_ALLOC: begin
            b = int'(open_cnt);
            while (b > 0 && !found) begin
               b--;
               if (free_cnt[b] != 0)
                  found = 1;
            end
            if (found) begin
               grant.handle = pop_block(b);
            end else if (open_cnt < MAX_BUFFERS) begin
               b = int'(open_cnt);
               open_cnt = open_cnt + 1'b1;
               build_list(b);
               grant.handle = pop_block(b);
            end else begin
               grant.status = STATUS_EXHAUSTED;
            end
            if (grant.status == STATUS_OK)
               live_handles.push_back(grant.handle);
         end
         REQ_FREE: begin
            b = int'(handle[HANDLE_W-1:IDX_W]);
            idx = int'(handle[IDX_W-1:0]);
            if (b >= open_cnt || idx >= usable_blocks()) begin
               grant.status = STATUS_BAD_HANDLE;
            end else begin
               link_mem[b * BPM + idx] = head_idx[b];
               head_idx[b] = CNT_W'(idx);
               if (free_cnt[b] < BPM)
                  free_cnt[b] = free_cnt[b] + 1'b1;
            end
         end
         REQ_FREE_ALL: begin
            for (b = 1; b < MAX_BUFFERS; b++) begin
               head_idx[b] = '0;
               free_cnt[b] = '0;
            end
            open_cnt = OPEN_W'(1);
            build_list(0);
            live_handles.delete();
         end
         default: begin
         end
      endcase
      expected_grants.push_back(grant);
   endtask

   // Driver: a word is held until the edge that accepts it, then the next one
   // follows after a drawn gap, or at once while a burst runs.
   always @(negedge clock) begin
      if (!reset) begin
         if (start && !word_taken) begin
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_words.size() > 0) begin
            next_word = pending_words.pop_front();
            start <= 1'b1;
            req_type <= next_word.kind;
            req_block_handle <= next_word.handle;
            if ($urandom_range(0, 15) == 0)
               burst <= !burst;
            gap_left <= burst ? 0 : int'($urandom_range(0, 3));
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      word_taken <= 1'b0;
      if (!reset && start && !busy) begin
         word_taken <= 1'b1;
         serve_request(req_type, req_block_handle);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_grants.size() == 0) begin
            $display("%0t: response word with none expected, handle %0d status %0d",
                     $time, rsp_granted_handle, rsp_status);
            failures++;
         end else begin
            got_grant = expected_grants.pop_front();
            if (rsp_granted_handle !== got_grant.handle) begin
               $display("%0t: granted_handle mismatch, expected %0d, actual %0d",
                        $time, got_grant.handle, rsp_granted_handle);
               failures++;
            end
            if (rsp_status !== got_grant.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, got_grant.status, rsp_status);
               failures++;
            end
         end
      end
   end

   task automatic queue_word(input logic [1:0] kind, input logic [HANDLE_W-1:0] handle);
      req_word_t w;
      w.kind = kind;
      w.handle = handle;
      // Keep the queue short so that frees pick from handles granted so far.
      while (pending_words.size() > 1)
         @(negedge clock);
      pending_words.push_back(w);
   endtask

   task automatic wait_idle();
      while (pending_words.size() > 0 || start || expected_grants.size() > 0 || busy)
         @(negedge clock);
   endtask

   task automatic write_blocks(input logic [CNT_W-1:0] value);
      wait_idle();
      // List building never trails the last response word; this wait only adds margin.
      repeat (BPM + 8) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      blocks_cfg = value;
   endtask

   task automatic run_random(input int count);
      int r;
      int j;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 45) begin
            queue_word(REQ_ALLOC, HANDLE_W'($urandom));
         end else if (r < 82 && live_handles.size() > 0) begin
            j = $urandom_range(0, live_handles.size() - 1);
            queue_word(REQ_FREE, live_handles[j]);
            // Leaving the handle in place now and then yields a double free.
            if ($urandom_range(0, 4) != 0)
               live_handles.delete(j);
         end else if (r < 94) begin
            queue_word(REQ_FREE, HANDLE_W'($urandom_range(0, 2047)));
         end else if (r < 97) begin
            queue_word(REQ_FREE_ALL, HANDLE_W'($urandom));
         end else begin
            queue_word(REQ_UNUSED, HANDLE_W'($urandom));
         end
      end
   endtask

   initial begin
      logic [CNT_W-1:0] settings [8];
      settings = '{9'd3, 9'd256, 9'd0, 9'd2, 9'd511, 9'd17, 9'd1, 9'd128};
      reset = 1'b1;
      reset_pool();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Full-size buffer 0: double free, bad buffer, a free of the highest block index past
      // the saturated count and the unused request code.
      queue_word(REQ_ALLOC, '0);
      queue_word(REQ_ALLOC, '1);
      queue_word(REQ_FREE, 11'd1);
      queue_word(REQ_FREE, 11'd1);
      queue_word(REQ_FREE, 11'd2047);
      queue_word(REQ_FREE, 11'd255);
      queue_word(REQ_UNUSED, 11'd2047);
      queue_word(REQ_FREE_ALL, '0);

      // One block per buffer fills the pool after eight allocations.
      write_blocks(9'd1);
      queue_word(REQ_FREE_ALL, '1);
      repeat (8) queue_word(REQ_ALLOC, '0);
      queue_word(REQ_ALLOC, '0);
      queue_word(REQ_FREE, 11'h700);
      queue_word(REQ_FREE, 11'h701);
      queue_word(REQ_ALLOC, '0);

      foreach (settings[i]) begin
         write_blocks(settings[i]);
         run_random(125);
      end

      wait_idle();
      repeat (BPM + 16) @(negedge clock);
      if (failures == 0)
         $display("fixed_block_pool_allocator verification clean");
      else
         $display("fixed_block_pool_allocator verification failed");
      $finish;
   end

   initial begin
      #16000000;
      $display("fixed_block_pool_allocator verification failed");
      $finish;
   end

endmodule
